>>> rtl/pbec_pkg.sv
package pbec_pkg;

	// Expected packet length is clamped to this before the length byte is formed.
	localparam int MAX_PAYLOAD = 127;
	localparam int TOTAL_WIDTH = 32;

	localparam int BITS_W = 12;
	localparam int BYTES_W = 9;
	localparam int OUT_TOTAL_W = 32;

	localparam int QUEUE_DEPTH = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_PAYLOAD_LENGTH = 1'b0;
	localparam logic REG_FILL_BYTE = 1'b1;
	localparam logic [6:0] PAYLOAD_LENGTH_RST = 7'd10;
	localparam logic [7:0] FILL_BYTE_RST = 8'hFF;

	typedef struct packed {
		logic action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic packet_lost;
		logic [BITS_W-1:0] packet_bad_bits;
		logic [BYTES_W-1:0] packet_bad_bytes;
		logic [OUT_TOTAL_W-1:0] total_packets;
		logic [OUT_TOTAL_W-1:0] total_bad_bits;
		logic [OUT_TOTAL_W-1:0] total_bad_bytes;
		logic [OUT_TOTAL_W-1:0] total_bad_packets;
		logic [OUT_TOTAL_W-1:0] total_lost_packets;
	} result_t;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_LOST,
		OP_START,
		OP_DATA
	} op_t;

	// One classified byte handed from the front to the back.
	typedef struct packed {
		op_t op;
		logic last;
		logic [BITS_W-1:0] bits;
		logic [BYTES_W-1:0] bytes;
	} cmd_t;

endpackage

>>> rtl/pbec_front.sv
module pbec_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input pbec_pkg::item_t item,
	input logic [6:0] payload_length,
	input logic [7:0] fill_byte,
	input logic q_full,
	output logic q_push,
	output pbec_pkg::cmd_t q_cmd
);

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	logic in_payload_q;
	logic [7:0] bytes_rem_q;
	logic [6:0] cmp_rem_q;

	logic [6:0] plen;
	logic [7:0] exp_len;
	logic [7:0] dif;
	logic [7:0] cmp_len;
	logic [3:0] byte_diff;
	logic last;

	assign item_ready = !q_full;
	assign q_push = item_valid && item_ready;

	always_comb begin
		plen = (payload_length == '0) ? 7'd1 : payload_length;
		if (8'(plen) > 8'(pbec_pkg::MAX_PAYLOAD)) begin
			exp_len = 8'(pbec_pkg::MAX_PAYLOAD) - 8'd1;
		end else begin
			exp_len = 8'(plen) - 8'd1;
		end
		dif = (exp_len > item.rx_byte) ? exp_len - item.rx_byte : item.rx_byte - exp_len;
		cmp_len = (exp_len < item.rx_byte) ? exp_len : item.rx_byte;
		byte_diff = (cmp_rem_q != '0) ? popcount8(item.rx_byte ^ fill_byte) : 4'd0;
		last = (bytes_rem_q == 8'd1);
	end

	// Classify the byte.
	always_comb begin
		q_cmd = '0;
		if (item.action) begin
			q_cmd.op = pbec_pkg::OP_CLEAR;
		end else if (!in_payload_q) begin
			if (item.rx_byte == '0) begin
				q_cmd.op = pbec_pkg::OP_LOST;
				q_cmd.last = 1'b1;
			end else begin
				q_cmd.op = pbec_pkg::OP_START;
				q_cmd.bits = {1'b0, dif, 3'b000} + 12'(popcount8(exp_len ^ item.rx_byte));
				q_cmd.bytes = {1'b0, dif} + 9'(dif != '0);
			end
		end else begin
			q_cmd.op = pbec_pkg::OP_DATA;
			q_cmd.last = last;
			q_cmd.bits = 12'(byte_diff);
			q_cmd.bytes = 9'(byte_diff != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			bytes_rem_q <= '0;
			cmp_rem_q <= '0;
		end else if (q_push && !item.action) begin
			if (!in_payload_q) begin
				if (item.rx_byte != '0) begin
					in_payload_q <= 1'b1;
					bytes_rem_q <= item.rx_byte;
					cmp_rem_q <= 7'(cmp_len);
				end
			end else begin
				bytes_rem_q <= bytes_rem_q - 8'd1;
				if (last) begin
					in_payload_q <= 1'b0;
					cmp_rem_q <= '0;
				end else if (cmp_rem_q != '0) begin
					cmp_rem_q <= cmp_rem_q - 7'd1;
				end
			end
		end
	end

endmodule

>>> rtl/pbec_queue.sv
module pbec_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input pbec_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output pbec_pkg::cmd_t head
);

	localparam int DEPTH = pbec_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pbec_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/pbec_back.sv
module pbec_back #(
	parameter int TOTAL_WIDTH = pbec_pkg::TOTAL_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input pbec_pkg::cmd_t head,
	output logic pop,
	output logic result_valid,
	input logic result_ready,
	output pbec_pkg::result_t result
);

	localparam int SW = TOTAL_WIDTH + 1;

	function automatic logic [TOTAL_WIDTH-1:0] sat_add(
		input logic [TOTAL_WIDTH-1:0] a,
		input logic [pbec_pkg::BITS_W-1:0] b
	);
		logic [SW-1:0] s;
		s = {1'b0, a} + SW'(b);
		return s[TOTAL_WIDTH] ? '1 : s[TOTAL_WIDTH-1:0];
	endfunction

	logic [pbec_pkg::BITS_W-1:0] run_bits_q;
	logic [pbec_pkg::BYTES_W-1:0] run_bytes_q;
	logic [TOTAL_WIDTH-1:0] sum_packets_q;
	logic [TOTAL_WIDTH-1:0] sum_bits_q;
	logic [TOTAL_WIDTH-1:0] sum_bytes_q;
	logic [TOTAL_WIDTH-1:0] sum_bad_q;
	logic [TOTAL_WIDTH-1:0] sum_lost_q;
	logic result_valid_q;
	pbec_pkg::result_t result_q;

	logic emits;
	logic out_free;
	logic is_lost;
	logic [pbec_pkg::BITS_W-1:0] new_bits;
	logic [pbec_pkg::BYTES_W-1:0] new_bytes;
	logic [TOTAL_WIDTH-1:0] nx_packets;
	logic [TOTAL_WIDTH-1:0] nx_bits;
	logic [TOTAL_WIDTH-1:0] nx_bytes;
	logic [TOTAL_WIDTH-1:0] nx_bad;
	logic [TOTAL_WIDTH-1:0] nx_lost;

	assign is_lost = (head.op == pbec_pkg::OP_LOST);
	assign emits = is_lost || (head.op == pbec_pkg::OP_DATA && head.last);
	assign out_free = !result_valid_q || result_ready;
	assign pop = head_valid && (!emits || out_free);
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		new_bits = is_lost ? '0 : run_bits_q + head.bits;
		new_bytes = is_lost ? '0 : run_bytes_q + head.bytes;
		nx_packets = sat_add(sum_packets_q, pbec_pkg::BITS_W'(1));
		nx_lost = is_lost ? sat_add(sum_lost_q, pbec_pkg::BITS_W'(1)) : sum_lost_q;
		nx_bits = is_lost ? sum_bits_q : sat_add(sum_bits_q, new_bits);
		nx_bytes = is_lost ? sum_bytes_q
			: sat_add(sum_bytes_q, pbec_pkg::BITS_W'(new_bytes));
		nx_bad = (!is_lost && new_bits != '0)
			? sat_add(sum_bad_q, pbec_pkg::BITS_W'(1)) : sum_bad_q;
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			result_q.packet_lost <= is_lost;
			result_q.packet_bad_bits <= new_bits;
			result_q.packet_bad_bytes <= new_bytes;
			result_q.total_packets <= pbec_pkg::OUT_TOTAL_W'(nx_packets);
			result_q.total_bad_bits <= pbec_pkg::OUT_TOTAL_W'(nx_bits);
			result_q.total_bad_bytes <= pbec_pkg::OUT_TOTAL_W'(nx_bytes);
			result_q.total_bad_packets <= pbec_pkg::OUT_TOTAL_W'(nx_bad);
			result_q.total_lost_packets <= pbec_pkg::OUT_TOTAL_W'(nx_lost);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bits_q <= '0;
			run_bytes_q <= '0;
			sum_packets_q <= '0;
			sum_bits_q <= '0;
			sum_bytes_q <= '0;
			sum_bad_q <= '0;
			sum_lost_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop && emits) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.op)
					pbec_pkg::OP_CLEAR: begin
						sum_packets_q <= '0;
						sum_bits_q <= '0;
						sum_bytes_q <= '0;
						sum_bad_q <= '0;
						sum_lost_q <= '0;
					end
					pbec_pkg::OP_START: begin
						run_bits_q <= head.bits;
						run_bytes_q <= head.bytes;
					end
					pbec_pkg::OP_LOST, pbec_pkg::OP_DATA: begin
						if (emits) begin
							sum_packets_q <= nx_packets;
							sum_bits_q <= nx_bits;
							sum_bytes_q <= nx_bytes;
							sum_bad_q <= nx_bad;
							sum_lost_q <= nx_lost;
							run_bits_q <= '0;
							run_bytes_q <= '0;
						end else begin
							run_bits_q <= new_bits;
							run_bytes_q <= new_bytes;
						end
					end
					default: begin
						run_bits_q <= run_bits_q;
					end
				endcase
			end
		end
	end

endmodule

>>> rtl/packet_bit_error_counter.sv
// Bit error counter for looped-back test packets.
// Request channel (item_valid/item_ready/item): one byte per request. With action
// low, rx_byte is a received byte; the first byte of each packet is its length.
// With action high, the five running totals clear and no result follows.
// Result channel (result_valid/result_ready/result): one result per finished
// packet, carrying that packet's bad bit and bad byte counts and the saturating
// totals. A zero length byte finishes a lost packet on its own.
// Throughput: one request per cycle while item_ready is high. The last byte of a
// packet reaches its result through the command queue and the result register.
// The front classifies each byte into a command; a two-entry command queue feeds
// the back, which accumulates counts and holds one result register. When the
// receiver stalls, the back holds the command that would finish a packet, the
// queue fills and item_ready drops once one more request is taken; bytes inside
// a packet still drain into the running counts.
// Configuration (APB, pready always high): payload_length at 0x0, fill_byte at
// 0x4; write only while no packet is in progress.
// Reset clears the totals, the packet state, the queue and the result valid, and
// loads payload_length 10 and fill_byte 0xFF.
module packet_bit_error_counter #(
	parameter int TOTAL_WIDTH = pbec_pkg::TOTAL_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pbec_pkg::PADDR_W-1:0] paddr,
	input logic [pbec_pkg::PDATA_W-1:0] pwdata,
	output logic [pbec_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input pbec_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output pbec_pkg::result_t result
);

	logic [6:0] payload_length_q;
	logic [7:0] fill_byte_q;
	logic reg_sel;

	logic q_full;
	logic q_push;
	pbec_pkg::cmd_t q_cmd;
	logic q_pop;
	logic q_valid;
	pbec_pkg::cmd_t q_head;

	// Decode by the word address; the low two bits are byte lanes.
	assign reg_sel = paddr[2];
	assign pready = 1'b1;

	always_comb begin
		case (reg_sel)
			pbec_pkg::REG_PAYLOAD_LENGTH: prdata = pbec_pkg::PDATA_W'(payload_length_q);
			pbec_pkg::REG_FILL_BYTE: prdata = pbec_pkg::PDATA_W'(fill_byte_q);
			default: prdata = '0;
		endcase
	end

	// Take the write in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= pbec_pkg::PAYLOAD_LENGTH_RST;
			fill_byte_q <= pbec_pkg::FILL_BYTE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				pbec_pkg::REG_PAYLOAD_LENGTH: payload_length_q <= pwdata[6:0];
				pbec_pkg::REG_FILL_BYTE: fill_byte_q <= pwdata[7:0];
				default: fill_byte_q <= fill_byte_q;
			endcase
		end
	end

	// Front: track packet framing and turn each byte into a command.
	pbec_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.payload_length(payload_length_q),
		.fill_byte(fill_byte_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	// Decouple the front from a stalled result port.
	pbec_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.head_valid(q_valid),
		.head(q_head)
	);

	// Back: accumulate packet counts and totals, present results.
	pbec_back #(
		.TOTAL_WIDTH(TOTAL_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(q_valid),
		.head(q_head),
		.pop(q_pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from empty queue");

	a_lost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.packet_lost |->
			result.packet_bad_bits == '0 && result.packet_bad_bytes == '0)
		else $error("lost packet carries damage counts");

	a_bytes_need_bits: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.packet_bad_bits == '0 |-> result.packet_bad_bytes == '0)
		else $error("bad bytes counted without bad bits");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_full && !q_pop |=> q_full)
		else $error("full queue drained without a pop");
`endif

endmodule
